[hw/rtl/bitmap_slot_allocator_defines.svh]
// assertion macros for the bitmap slot allocator
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define BSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bitmap slot allocator: same-cycle check failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define BSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bitmap slot allocator: next-cycle check failed");

`endif

[hw/rtl/bsa_pkg.sv]
// shared constants for the bitmap slot allocator
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

  // default geometry of the free map
  localparam int MAX_WORDS_DEF = 8;
  localparam int WORD_BITS_DEF = 64;

  // payload field widths
  localparam int OP_W     = 1;
  localparam int IDX_W    = 9;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 4;

  // pool size after reset
  localparam logic [CFG_W-1:0] POOL_RESET = 4'd1;

  // request operations
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

`default_nettype wire

[hw/rtl/bsa_if.sv]
// request and response channel interfaces for the bitmap slot allocator
`timescale 1ns / 1ps
`default_nettype none

interface bsa_req_if;
  logic                       valid;
  logic                       ready;
  logic [bsa_pkg::OP_W-1:0]   operation;
  logic [bsa_pkg::IDX_W-1:0]  slot_index;

  modport source (output valid, output operation, output slot_index, input ready);
  modport sink   (input valid, input operation, input slot_index, output ready);
endinterface

interface bsa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bsa_pkg::STATUS_W-1:0] status;
  logic [bsa_pkg::IDX_W-1:0]    granted_index;

  modport source (output valid, output status, output granted_index, input ready);
  modport sink   (input valid, input status, input granted_index, output ready);
endinterface

`default_nettype wire

[hw/rtl/bitmap_slot_allocator.sv]
// bitmap slot allocator: free map, request register and response register
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    operation, slot_index
//   rsp      out  valid/ready    status, granted_index
//   cfg      in   cfg_wr_en      cfg_wr_data (pool_words)
//
// one request per cycle unless rsp stalls; each passes both registers
// the free map update and the response are written at the same edge, so
// the next request sees the map as left by the previous one
// a stalled rsp holds the request register; req.ready drops once both fill
// synchronous reset sets every free map bit and the pool size to one word
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_slot_allocator_defines.svh"

module bitmap_slot_allocator #(
  parameter int MAX_WORDS = bsa_pkg::MAX_WORDS_DEF,
  parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [bsa_pkg::CFG_W-1:0] cfg_wr_data,
  bsa_req_if.sink                        req,
  bsa_rsp_if.source                      rsp
);

  localparam int BIW   = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int SW    = $clog2(MAX_WORDS * WORD_BITS + 1);
  localparam int CW    = (SW > bsa_pkg::IDX_W + 1) ? SW : bsa_pkg::IDX_W + 1;

  // state
  logic [WORD_BITS-1:0]          free_map      [MAX_WORDS];
  logic [WORD_BITS-1:0]          free_map_next [MAX_WORDS];
  logic [bsa_pkg::CFG_W-1:0]     pool_words;

  // request register
  logic                          in_valid;
  logic [bsa_pkg::OP_W-1:0]      in_op;
  logic [bsa_pkg::IDX_W-1:0]     in_slot;

  // response register
  logic                          out_valid;
  logic [bsa_pkg::STATUS_W-1:0]  out_status;
  logic [bsa_pkg::IDX_W-1:0]     out_granted;
  logic [bsa_pkg::STATUS_W-1:0]  out_status_next;
  logic [bsa_pkg::IDX_W-1:0]     out_granted_next;

  // lookup signals
  logic                          advance;
  logic [MAX_WORDS-1:0]          active;
  logic [MAX_WORDS-1:0]          avail;
  logic [MAX_WORDS-1:0]          hit;
  logic [MAX_WORDS-1:0]          word_oh;
  logic [WORD_BITS-1:0]          set_mask [MAX_WORDS];
  logic [WORD_BITS-1:0]          sel_word;
  logic [WORD_BITS-1:0]          bit_oh;
  logic [BIW-1:0]                bit_idx;
  logic [CW-1:0]                 grant_base;
  logic [CW-1:0]                 grant_full;
  logic                          any_avail;
  logic                          any_hit;

  // handshake
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.granted_index = out_granted;

  // per-word pool membership, free-index decode and availability
  always_comb begin
    logic [CW-1:0] base;
    logic [CW-1:0] ofs;
    for (int w = 0; w < MAX_WORDS; w++) begin
      base        = CW'(w * WORD_BITS);
      ofs         = CW'(in_slot) - base;
      active[w]   = (w == 0) || (32'(pool_words) > 32'(w));
      hit[w]      = active[w] && (CW'(in_slot) >= base)
                    && (CW'(in_slot) < base + CW'(WORD_BITS));
      set_mask[w] = hit[w] ? ({{(WORD_BITS-1){1'b0}}, 1'b1} << ofs[BIW-1:0])
                           : '0;
      avail[w]    = active[w] && (|free_map[w]);
    end
  end

  assign any_avail = |avail;
  assign any_hit   = |hit;

  // lowest word with a free slot, then lowest free bit inside it
  assign word_oh = avail & (~avail + MAX_WORDS'(1));

  always_comb begin
    sel_word   = '0;
    grant_base = '0;
    for (int w = 0; w < MAX_WORDS; w++) begin
      if (word_oh[w]) begin
        sel_word   = sel_word | free_map[w];
        grant_base = grant_base | CW'(w * WORD_BITS);
      end
    end
  end

  assign bit_oh = sel_word & (~sel_word + WORD_BITS'(1));

  always_comb begin
    bit_idx = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (bit_oh[b]) begin
        bit_idx = bit_idx | BIW'(b);
      end
    end
  end

  assign grant_full = grant_base + CW'(bit_idx);

  // response fields and free map update
  always_comb begin
    out_status_next  = bsa_pkg::ST_DONE;
    out_granted_next = '0;
    for (int w = 0; w < MAX_WORDS; w++) begin
      free_map_next[w] = free_map[w];
    end
    if (in_op == bsa_pkg::OP_ALLOC) begin
      if (any_avail) begin
        out_granted_next = grant_full[bsa_pkg::IDX_W-1:0];
        for (int w = 0; w < MAX_WORDS; w++) begin
          if (word_oh[w]) begin
            free_map_next[w] = free_map[w] & ~bit_oh;
          end
        end
      end else begin
        out_status_next = bsa_pkg::ST_EMPTY;
      end
    end else begin
      if (any_hit) begin
        for (int w = 0; w < MAX_WORDS; w++) begin
          free_map_next[w] = free_map[w] | set_mask[w];
        end
      end else begin
        out_status_next = bsa_pkg::ST_RANGE;
      end
    end
  end

  // pool size register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_words <= bsa_pkg::POOL_RESET;
    end else if (cfg_wr_en) begin
      pool_words <= cfg_wr_data;
    end
  end

  // free map
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < MAX_WORDS; w++) begin
        free_map[w] <= '1;
      end
    end else if (advance) begin
      for (int w = 0; w < MAX_WORDS; w++) begin
        free_map[w] <= free_map_next[w];
      end
    end
  end

  // request register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // request register payload
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_op   <= req.operation;
      in_slot <= req.slot_index;
    end
  end

  // response register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // response register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_status  <= out_status_next;
      out_granted <= out_granted_next;
    end
  end

  // checks
  `BSA_ASSERT_NOW(a_empty_no_grant, out_valid && out_status != bsa_pkg::ST_DONE, out_granted == '0)
  `BSA_ASSERT_NEXT(a_alloc_granted, advance && in_op == bsa_pkg::OP_ALLOC && any_avail, out_valid && out_status == bsa_pkg::ST_DONE)
  `BSA_ASSERT_NEXT(a_request_held, in_valid && !advance, in_valid && $stable(in_slot) && $stable(in_op))

endmodule

`default_nettype wire
